// ----- sv/buddy_block_allocator_assert.svh -----
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bba_pkg.sv -----
`default_nettype none

package bba_pkg;

    localparam int TOP_BLOCKS_DEF      = 32;
    localparam int MAX_LEVEL_DEF       = 10;
    localparam int MIN_BLOCK_BYTES_DEF = 128;
    localparam int SIZE_LIMIT          = 100000000;
    localparam logic [6:0] HDR_RESET   = 7'd32;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_BADSIZE = 3'd2;
    localparam logic [2:0] ST_MAP     = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_A_SEL,
        S_A_SCAN_RD,
        S_A_SCAN_CHK,
        S_A_SPLIT,
        S_A_SPLIT_WR,
        S_A_LIVE_WR,
        S_F_CHK,
        S_F_LOOP,
        S_F_BUD_CHK,
        S_F_SET_WR,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_TARGET,
        OP_SEL,
        OP_SCAN_RD,
        OP_SCAN_HIT,
        OP_SCAN_NEXT,
        OP_SPLIT_RD,
        OP_SPLIT_WR,
        OP_LIVE_RD,
        OP_LIVE_WR,
        OP_F_RD,
        OP_F_CLR,
        OP_BUD_RD,
        OP_MERGE,
        OP_SET_RD,
        OP_SET_WR,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] st;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic is_free;
        logic bad;
        logic map;
        logic none;
        logic hit;
        logic ord_gt_tgt;
        logic ord_max;
        logic live_hit;
        logic buddy_free;
        logic out_busy;
    } sts_t;

    // 32-bit words holding the free bits of one order
    function automatic int lvl_words(input int lvl, input int top, input int maxl);
        return ((top << (maxl - lvl)) + 31) >> 5;
    endfunction

    // first word of an order in the free-bit memory
    function automatic int lvl_base_words(input int lvl, input int top, input int maxl);
        int acc;
        acc = 0;
        for (int k = 0; k < lvl; k++)
        begin
            acc += lvl_words(k, top, maxl);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bba_ctrl.sv -----
`default_nettype none

module bba_ctrl (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);

    bba_pkg::state_t state_reg, state_next;
    logic [2:0]      st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_INIT;
            st_reg    <= bba_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        case (state_reg)
            bba_pkg::S_INIT:
            begin
                if (sts.init_last)
                    state_next = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = bba_pkg::S_DECODE;
            end
            bba_pkg::S_DECODE:
            begin
                if (sts.is_free)
                    state_next = bba_pkg::S_F_CHK;
                else if (sts.bad)
                begin
                    st_next    = bba_pkg::ST_BADSIZE;
                    state_next = bba_pkg::S_DONE;
                end
                else if (sts.map)
                begin
                    st_next    = bba_pkg::ST_MAP;
                    state_next = bba_pkg::S_DONE;
                end
                else
                    state_next = bba_pkg::S_A_SEL;
            end
            bba_pkg::S_A_SEL:
            begin
                if (sts.none)
                begin
                    st_next    = bba_pkg::ST_NOSPACE;
                    state_next = bba_pkg::S_DONE;
                end
                else
                    state_next = bba_pkg::S_A_SCAN_RD;
            end
            bba_pkg::S_A_SCAN_RD:
                state_next = bba_pkg::S_A_SCAN_CHK;
            bba_pkg::S_A_SCAN_CHK:
            begin
                if (sts.hit)
                    state_next = bba_pkg::S_A_SPLIT;
                else
                    state_next = bba_pkg::S_A_SCAN_RD;
            end
            bba_pkg::S_A_SPLIT:
            begin
                if (sts.ord_gt_tgt)
                    state_next = bba_pkg::S_A_SPLIT_WR;
                else
                    state_next = bba_pkg::S_A_LIVE_WR;
            end
            bba_pkg::S_A_SPLIT_WR:
                state_next = bba_pkg::S_A_SPLIT;
            bba_pkg::S_A_LIVE_WR:
            begin
                st_next    = bba_pkg::ST_OK;
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_F_CHK:
            begin
                if (!sts.live_hit)
                begin
                    st_next    = bba_pkg::ST_IGNORED;
                    state_next = bba_pkg::S_DONE;
                end
                else
                    state_next = bba_pkg::S_F_LOOP;
            end
            bba_pkg::S_F_LOOP:
            begin
                if (sts.ord_max)
                    state_next = bba_pkg::S_F_SET_WR;
                else
                    state_next = bba_pkg::S_F_BUD_CHK;
            end
            bba_pkg::S_F_BUD_CHK:
            begin
                if (sts.buddy_free)
                    state_next = bba_pkg::S_F_LOOP;
                else
                    state_next = bba_pkg::S_F_SET_WR;
            end
            bba_pkg::S_F_SET_WR:
            begin
                st_next    = bba_pkg::ST_OK;
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                    state_next = bba_pkg::S_IDLE;
            end
            default:
                state_next = bba_pkg::S_INIT;
        endcase
    end

    always_comb
    begin
        cmd.op   = bba_pkg::OP_NONE;
        cmd.st   = st_reg;
        in_ready = 1'b0;
        case (state_reg)
            bba_pkg::S_INIT:
                cmd.op = bba_pkg::OP_INIT;
            bba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = bba_pkg::OP_LOAD;
            end
            bba_pkg::S_DECODE:
            begin
                if (sts.is_free)
                    cmd.op = bba_pkg::OP_F_RD;
                else if (!sts.bad && !sts.map)
                    cmd.op = bba_pkg::OP_TARGET;
            end
            bba_pkg::S_A_SEL:
            begin
                if (!sts.none)
                    cmd.op = bba_pkg::OP_SEL;
            end
            bba_pkg::S_A_SCAN_RD:
                cmd.op = bba_pkg::OP_SCAN_RD;
            bba_pkg::S_A_SCAN_CHK:
                cmd.op = sts.hit ? bba_pkg::OP_SCAN_HIT : bba_pkg::OP_SCAN_NEXT;
            bba_pkg::S_A_SPLIT:
                cmd.op = sts.ord_gt_tgt ? bba_pkg::OP_SPLIT_RD : bba_pkg::OP_LIVE_RD;
            bba_pkg::S_A_SPLIT_WR:
                cmd.op = bba_pkg::OP_SPLIT_WR;
            bba_pkg::S_A_LIVE_WR:
                cmd.op = bba_pkg::OP_LIVE_WR;
            bba_pkg::S_F_CHK:
            begin
                if (sts.live_hit)
                    cmd.op = bba_pkg::OP_F_CLR;
            end
            bba_pkg::S_F_LOOP:
                cmd.op = sts.ord_max ? bba_pkg::OP_SET_RD : bba_pkg::OP_BUD_RD;
            bba_pkg::S_F_BUD_CHK:
                cmd.op = sts.buddy_free ? bba_pkg::OP_MERGE : bba_pkg::OP_SET_RD;
            bba_pkg::S_F_SET_WR:
                cmd.op = bba_pkg::OP_SET_WR;
            bba_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                    cmd.op = bba_pkg::OP_EMIT;
            end
            default:
                cmd.op = bba_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/bba_datapath.sv -----
`default_nettype none

module bba_datapath #(
    parameter int TOP_BLOCKS      = bba_pkg::TOP_BLOCKS_DEF,
    parameter int MAX_LEVEL       = bba_pkg::MAX_LEVEL_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           cfg_we,
    input  wire  [6:0]    cfg_wdata,
    input  wire           in_func,
    input  wire  [26:0]   in_req,
    input  wire  [14:0]   in_idx,
    input  bba_pkg::cmd_t cmd,
    output bba_pkg::sts_t sts,
    output logic          out_valid,
    input  wire           out_ready,
    output logic [2:0]    out_status,
    output logic [14:0]   out_index,
    output logic [3:0]    out_order
);

    localparam int UNITS    = TOP_BLOCKS << MAX_LEVEL;
    localparam int UAW      = $clog2(UNITS);
    localparam int UW       = (UAW > 5) ? UAW : 5;
    localparam int OW       = $clog2(MAX_LEVEL + 1);
    localparam int FW       = bba_pkg::lvl_base_words(MAX_LEVEL + 1, TOP_BLOCKS, MAX_LEVEL);
    localparam int FAW      = $clog2((FW > 1) ? FW : 2);
    localparam int TOP_BASE = bba_pkg::lvl_base_words(MAX_LEVEL, TOP_BLOCKS, MAX_LEVEL);
    localparam int LW       = (UNITS + 31) >> 5;
    localparam int LAW      = $clog2((LW > 1) ? LW : 2);
    localparam int SW       = (FW > LW) ? FW : LW;
    localparam int SAW      = $clog2((SW > 1) ? SW : 2);
    localparam int CW       = $clog2(UNITS + 1);
    localparam logic [29:0] LARGEST = 30'(MIN_BLOCK_BYTES << MAX_LEVEL);

    logic [31:0]    fmem [FW];
    logic [31:0]    lmem [LW];
    logic [OW-1:0]  vmem [UNITS];

    logic [FAW-1:0] lvl_base [MAX_LEVEL+1];

    genvar g;
    generate
        for (g = 0; g <= MAX_LEVEL; g++)
        begin : g_base
            assign lvl_base[g] = FAW'(bba_pkg::lvl_base_words(g, TOP_BLOCKS, MAX_LEVEL));
        end
    endgenerate

    logic [6:0]     hdr_reg;
    logic           func_reg;
    logic [26:0]    req_reg;
    logic [14:0]    idx_reg;
    logic [OW-1:0]  target_reg;
    logic [OW-1:0]  ord_reg;
    logic [UW-1:0]  unit_reg;
    logic [FAW-1:0] word_reg;
    logic [FAW-1:0] fa_reg;
    logic [4:0]     fb_reg;
    logic [LAW-1:0] la_reg;
    logic [4:0]     lb_reg;
    logic [SAW-1:0] swp_reg;
    logic [CW-1:0]  cnt_reg [MAX_LEVEL+1];
    logic [31:0]    frd_reg;
    logic [31:0]    lrd_reg;
    logic [OW-1:0]  vrd_reg;
    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic [14:0]    out_index_reg;
    logic [3:0]     out_order_reg;

    logic [29:0]    needed;
    logic [OW-1:0]  tgt_calc;
    logic [OW-1:0]  sel_ord;
    logic           none;
    logic           hit;
    logic [4:0]     hit_bit;
    logic           ign_range;
    logic [OW-1:0]  a_lvl;
    logic [UW-1:0]  a_unit;
    logic [UW-1:0]  a_pos;
    logic           fre;
    logic [FAW-1:0] fra;
    logic           fwe;
    logic [FAW-1:0] fwa;
    logic [31:0]    fwd;
    logic [31:0]    init_word;
    logic           lre;
    logic [UW-1:0]  l_unit;
    logic           lwe;
    logic [LAW-1:0] lwa;
    logic [31:0]    lwd;
    logic [UW-1:0]  scan_unit;
    logic [UW-1:0]  merge_unit;

    assign needed    = {3'b000, req_reg} + 30'(hdr_reg);
    assign ign_range = {17'b0, idx_reg} >= 32'(UNITS);

    always_comb
    begin
        tgt_calc = OW'(MAX_LEVEL);
        for (int k = MAX_LEVEL; k >= 0; k--)
        begin
            if ((30'(MIN_BLOCK_BYTES) << k) >= needed)
                tgt_calc = OW'(k);
        end
    end

    always_comb
    begin
        sel_ord = ord_reg;
        none    = 1'b1;
        for (int k = MAX_LEVEL; k >= 0; k--)
        begin
            if ((OW'(k) >= target_reg) && (cnt_reg[k] != '0))
            begin
                sel_ord = OW'(k);
                none    = 1'b0;
            end
        end
    end

    always_comb
    begin
        hit     = frd_reg != 32'd0;
        hit_bit = 5'd0;
        for (int b = 31; b >= 0; b--)
        begin
            if (frd_reg[b])
                hit_bit = 5'(b);
        end
    end

    always_comb
    begin
        init_word = 32'd0;
        for (int b = 0; b < 32; b++)
        begin
            if ((int'(swp_reg) >= TOP_BASE)
                && (((int'(swp_reg) - TOP_BASE) << 5) + b < TOP_BLOCKS))
                init_word[b] = 1'b1;
        end
    end

    // free-bit address of a block at an order
    always_comb
    begin
        a_lvl  = ord_reg;
        a_unit = unit_reg;
        case (cmd.op)
            bba_pkg::OP_SPLIT_RD:
            begin
                a_lvl  = ord_reg - OW'(1);
                a_unit = unit_reg | (UW'(1) << (ord_reg - OW'(1)));
            end
            bba_pkg::OP_BUD_RD:
                a_unit = unit_reg ^ (UW'(1) << ord_reg);
            default:
            begin
                a_lvl  = ord_reg;
                a_unit = unit_reg;
            end
        endcase
    end

    assign a_pos = a_unit >> a_lvl;
    assign fre   = (cmd.op == bba_pkg::OP_SCAN_RD) || (cmd.op == bba_pkg::OP_SPLIT_RD)
                || (cmd.op == bba_pkg::OP_BUD_RD) || (cmd.op == bba_pkg::OP_SET_RD);
    assign fra   = (cmd.op == bba_pkg::OP_SCAN_RD) ? lvl_base[ord_reg] + word_reg
                                                   : lvl_base[a_lvl] + FAW'(a_pos >> 5);

    always_comb
    begin
        fwe = 1'b0;
        fwa = fa_reg;
        fwd = frd_reg;
        case (cmd.op)
            bba_pkg::OP_INIT:
            begin
                fwe = int'(swp_reg) < FW;
                fwa = FAW'(swp_reg);
                fwd = init_word;
            end
            bba_pkg::OP_SCAN_HIT:
            begin
                fwe = 1'b1;
                fwd = frd_reg & ~(32'd1 << hit_bit);
            end
            bba_pkg::OP_MERGE:
            begin
                fwe = 1'b1;
                fwd = frd_reg & ~(32'd1 << fb_reg);
            end
            bba_pkg::OP_SPLIT_WR, bba_pkg::OP_SET_WR:
            begin
                fwe = 1'b1;
                fwd = frd_reg | (32'd1 << fb_reg);
            end
            default:
                fwe = 1'b0;
        endcase
    end

    assign lre    = (cmd.op == bba_pkg::OP_F_RD) || (cmd.op == bba_pkg::OP_LIVE_RD);
    assign l_unit = (cmd.op == bba_pkg::OP_F_RD) ? UW'(idx_reg) : unit_reg;

    always_comb
    begin
        lwe = 1'b0;
        lwa = la_reg;
        lwd = lrd_reg;
        case (cmd.op)
            bba_pkg::OP_INIT:
            begin
                lwe = int'(swp_reg) < LW;
                lwa = LAW'(swp_reg);
                lwd = 32'd0;
            end
            bba_pkg::OP_LIVE_WR:
            begin
                lwe = 1'b1;
                lwd = lrd_reg | (32'd1 << lb_reg);
            end
            bba_pkg::OP_F_CLR:
            begin
                lwe = 1'b1;
                lwd = lrd_reg & ~(32'd1 << lb_reg);
            end
            default:
                lwe = 1'b0;
        endcase
    end

    assign scan_unit  = UW'({word_reg, hit_bit}) << ord_reg;
    assign merge_unit = unit_reg & ~(UW'(1) << ord_reg);

    always_ff @(posedge clk)
    begin
        if (fwe)
            fmem[fwa] <= fwd;
        if (fre)
            frd_reg <= fmem[fra];
    end

    always_ff @(posedge clk)
    begin
        if (lwe)
            lmem[lwa] <= lwd;
        if (lre)
            lrd_reg <= lmem[LAW'(l_unit >> 5)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == bba_pkg::OP_LIVE_WR)
            vmem[unit_reg[UAW-1:0]] <= target_reg;
        if (cmd.op == bba_pkg::OP_F_RD)
            vrd_reg <= vmem[l_unit[UAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= bba_pkg::HDR_RESET;
            swp_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= MAX_LEVEL; k++)
            begin
                cnt_reg[k] <= (k == MAX_LEVEL) ? CW'(TOP_BLOCKS) : '0;
            end
        end
        else
        begin
            if (cfg_we)
                hdr_reg <= cfg_wdata;
            if (cmd.op == bba_pkg::OP_INIT)
                swp_reg <= swp_reg + SAW'(1);
            if (cmd.op == bba_pkg::OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                bba_pkg::OP_SCAN_HIT, bba_pkg::OP_MERGE:
                    cnt_reg[ord_reg] <= cnt_reg[ord_reg] - CW'(1);
                bba_pkg::OP_SPLIT_WR, bba_pkg::OP_SET_WR:
                    cnt_reg[ord_reg] <= cnt_reg[ord_reg] + CW'(1);
                default:
                    cnt_reg[ord_reg] <= cnt_reg[ord_reg];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fre)
        begin
            fa_reg <= fra;
            fb_reg <= a_pos[4:0];
        end
        if (lre)
        begin
            la_reg <= LAW'(l_unit >> 5);
            lb_reg <= l_unit[4:0];
        end
        case (cmd.op)
            bba_pkg::OP_LOAD:
            begin
                func_reg <= in_func;
                req_reg  <= in_req;
                idx_reg  <= in_idx;
            end
            bba_pkg::OP_TARGET:
                target_reg <= tgt_calc;
            bba_pkg::OP_SEL:
            begin
                ord_reg  <= sel_ord;
                word_reg <= '0;
            end
            bba_pkg::OP_SCAN_NEXT:
                word_reg <= word_reg + FAW'(1);
            bba_pkg::OP_SCAN_HIT:
                unit_reg <= scan_unit;
            bba_pkg::OP_SPLIT_RD:
                ord_reg <= ord_reg - OW'(1);
            bba_pkg::OP_F_RD:
                unit_reg <= UW'(idx_reg);
            bba_pkg::OP_F_CLR:
                ord_reg <= (vrd_reg > OW'(MAX_LEVEL)) ? OW'(MAX_LEVEL) : vrd_reg;
            bba_pkg::OP_MERGE:
            begin
                unit_reg <= merge_unit;
                ord_reg  <= ord_reg + OW'(1);
            end
            bba_pkg::OP_EMIT:
            begin
                out_status_reg <= cmd.st;
                out_index_reg  <= (cmd.st == bba_pkg::ST_OK) ? 15'(unit_reg) : 15'd0;
                out_order_reg  <= (cmd.st == bba_pkg::ST_OK) ? 4'(ord_reg) : 4'd0;
            end
            default:
                word_reg <= word_reg;
        endcase
    end

    assign sts.init_last  = swp_reg == SAW'(SW - 1);
    assign sts.is_free    = func_reg;
    assign sts.bad        = (req_reg == 27'd0) || ({3'b000, req_reg} > 30'(bba_pkg::SIZE_LIMIT));
    assign sts.map        = ({3'b000, req_reg} >= LARGEST) || (needed > LARGEST);
    assign sts.none       = none;
    assign sts.hit        = hit;
    assign sts.ord_gt_tgt = ord_reg > target_reg;
    assign sts.ord_max    = ord_reg == OW'(MAX_LEVEL);
    assign sts.live_hit   = lrd_reg[lb_reg] && !ign_range;
    assign sts.buddy_free = frd_reg[fb_reg];
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_order  = out_order_reg;

endmodule

`default_nettype wire

// ----- sv/buddy_block_allocator.sv -----
// buddy block allocator, one request beat in, one result beat out
// s_tuser carries the operation (allocate or free), s_tdata the size and
// the block index; m_tdata carries status, block index and order
// header_bytes is written through cfg_we / cfg_wdata; write it only while idle, as the block does not enforce this
// after reset a clearing pass writes the free-bit and live-bit memories;
// it sweeps max(free words, live words) addresses, 2047 at the default
// sizes, and s_tready stays low until it ends
// one request at a time: an allocate scans the chosen order's free words
// for a set bit, then splits down to the target order and writes the
// live bit; a free clears the live bit, merges free buddies up the orders
// and sets the free bit; each split and merge step reads the free-bit
// memory, then writes it; error and ignored answers end early
// per-order free counters let the search go straight to a non-empty order
// the result sits in an output register; a new request is taken while it
// waits, and a finished result waits for m_tready before it is written
`default_nettype none

module buddy_block_allocator #(
    parameter int TOP_BLOCKS      = bba_pkg::TOP_BLOCKS_DEF,
    parameter int MAX_LEVEL       = bba_pkg::MAX_LEVEL_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // req_size[26:0], block_index[41:27], zero
    input  wire  [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // status[2:0], result_index[17:3], result_order[21:18]
);

    `include "buddy_block_allocator_assert.svh"

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;
    logic [2:0]    out_status;
    logic [14:0]   out_index;
    logic [3:0]    out_order;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath #(
        .TOP_BLOCKS      (TOP_BLOCKS),
        .MAX_LEVEL       (MAX_LEVEL),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser[0]),
        .in_req     (s_tdata[26:0]),
        .in_idx     (s_tdata[41:27]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_index  (out_index),
        .out_order  (out_order)
    );

    assign m_tdata = {2'b00, out_order, out_index, out_status};

    `BBA_ASSERT_IMPL(a_init_blocks_input, cmd.op == bba_pkg::OP_INIT, !s_tready, "input taken during clearing pass")
    `BBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
    `BBA_ASSERT_IMPL(a_no_overwrite, cmd.op == bba_pkg::OP_EMIT, !(m_tvalid && !m_tready), "pending result overwritten")
    `BBA_ASSERT_IMPL(a_err_fields_zero, m_tvalid && (m_tdata[2:0] != bba_pkg::ST_OK), m_tdata[21:3] == 19'd0, "error result carries index or order")

endmodule

`default_nettype wire
